[sv/token_lexer_number_parser_assert.svh]
// Assertion macros shared by the lexer's checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef TOKEN_LEXER_NUMBER_PARSER_ASSERT_SVH
`define TOKEN_LEXER_NUMBER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLNP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/tlnp_pkg.sv]
// Shared types, character codes and helper functions for the token lexer.
// No dependencies; used by tlnp_core and the top level.
package tlnp_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 31;

    localparam logic [7:0] CH_FIRST_TOK = 8'd33;
    localparam logic [7:0] CH_LAST_TOK  = 8'd126;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_LOWER_O   = 8'h6f;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_QUOTE     = 8'h27;

    // Digit code that matches no radix.
    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TOKEN = 2'd1,
        MODE_SKIP  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef struct packed {
        logic               is_number;
        logic signed [31:0] number_value;
        logic [4:0]         token_length;
        logic               truncated;
    } t_result;

    function automatic logic is_prefix(input logic [7:0] c);
        return (c == CH_PERCENT) || (c == CH_LOWER_O) || (c == CH_HASH) || (c == CH_DOLLAR);
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41) + 5'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61) + 5'd10;
        end else begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_value(input t_radix r);
        logic [4:0] v;
        unique case (r)
            RADIX_BIN: v = 5'd2;
            RADIX_OCT: v = 5'd8;
            RADIX_HEX: v = 5'd16;
            default:   v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

[sv/tlnp_core.sv]
// Lexer state and per-character update: token tracking, radix prefix,
// digit accumulation, comment skip and the result of a finished token.
// Depends on tlnp_pkg.
module tlnp_core #(
    parameter int MAX_TOKEN_LEN = tlnp_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_char,
    input  logic               i_eoi,
    output logic               o_emit,
    output tlnp_pkg::t_result  o_result
);

    localparam int CW_RAW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CW     = (CW_RAW > 5) ? CW_RAW : 5;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TOKEN_LEN);

    tlnp_pkg::t_mode  r_mode,   n_mode;
    logic [CW-1:0]    r_count,  n_count;
    logic [31:0]      r_acc,    n_acc;
    tlnp_pkg::t_radix r_radix,  n_radix;
    logic             r_dv,     n_dv;
    logic [7:0]       r_first,  n_first;
    logic [7:0]       r_second, n_second;
    logic             r_third_q, n_third_q;
    logic             r_ovf,    n_ovf;

    // Absorb path: base state is the current token, or a fresh one
    logic             tok_char;
    logic             in_token;
    logic [CW-1:0]    b_count;
    logic [31:0]      b_acc;
    tlnp_pkg::t_radix b_radix;
    logic             b_dv;
    logic [7:0]       b_first;
    logic [7:0]       b_second;
    logic             b_third_q;
    logic             b_ovf;

    logic [CW-1:0]    a_count;
    logic [31:0]      a_acc;
    tlnp_pkg::t_radix a_radix;
    logic             a_dv;
    logic [7:0]       a_first;
    logic [7:0]       a_second;
    logic             a_third_q;
    logic             a_ovf;

    logic [4:0]       digit;
    logic [31:0]      scaled;
    logic             is_comment;
    logic             is_literal;
    logic             num;

    assign tok_char = !i_eoi && (i_char >= tlnp_pkg::CH_FIRST_TOK)
                      && (i_char <= tlnp_pkg::CH_LAST_TOK);
    assign in_token = (r_mode == tlnp_pkg::MODE_TOKEN);

    always_comb begin
        if (in_token) begin
            b_count   = r_count;
            b_acc     = r_acc;
            b_radix   = r_radix;
            b_dv      = r_dv;
            b_first   = r_first;
            b_second  = r_second;
            b_third_q = r_third_q;
            b_ovf     = r_ovf;
        end else begin
            b_count   = '0;
            b_acc     = '0;
            b_radix   = tlnp_pkg::RADIX_DEC;
            b_dv      = 1'b1;
            b_first   = '0;
            b_second  = '0;
            b_third_q = 1'b0;
            b_ovf     = 1'b0;
        end
    end

    assign digit = tlnp_pkg::digit_of(i_char);

    // Multiply by the radix as shifts and one add
    always_comb begin
        unique case (b_radix)
            tlnp_pkg::RADIX_BIN: scaled = {b_acc[30:0], 1'b0};
            tlnp_pkg::RADIX_OCT: scaled = {b_acc[28:0], 3'b000};
            tlnp_pkg::RADIX_HEX: scaled = {b_acc[27:0], 4'b0000};
            default:             scaled = {b_acc[28:0], 3'b000} + {b_acc[30:0], 1'b0};
        endcase
    end

    always_comb begin
        a_first   = (b_count == '0)      ? i_char : b_first;
        a_second  = (b_count == CW'(1))  ? i_char : b_second;
        a_third_q = (b_count == CW'(2))  ? (i_char == tlnp_pkg::CH_QUOTE) : b_third_q;
        a_radix   = b_radix;
        a_dv      = b_dv;
        a_acc     = b_acc;
        if (b_count == '0 && tlnp_pkg::is_prefix(i_char)) begin
            if (i_char == tlnp_pkg::CH_PERCENT) begin
                a_radix = tlnp_pkg::RADIX_BIN;
            end else if (i_char == tlnp_pkg::CH_LOWER_O) begin
                a_radix = tlnp_pkg::RADIX_OCT;
            end else if (i_char == tlnp_pkg::CH_DOLLAR) begin
                a_radix = tlnp_pkg::RADIX_HEX;
            end else begin
                a_radix = tlnp_pkg::RADIX_DEC;
            end
        end else if (digit >= tlnp_pkg::radix_value(b_radix)) begin
            a_dv = 1'b0;
        end else begin
            a_acc = scaled + {27'd0, digit};
        end
        if (b_count < CNT_MAX) begin
            a_count = b_count + CW'(1);
            a_ovf   = b_ovf;
        end else begin
            a_count = b_count;
            a_ovf   = 1'b1;
        end
    end

    // Token end decode, on the current token state
    assign is_comment = !r_ovf && (r_count == CW'(2)) && (r_first == tlnp_pkg::CH_SLASH)
                        && (r_second == tlnp_pkg::CH_SLASH);
    assign is_literal = !r_ovf && (r_count == CW'(3)) && (r_first == tlnp_pkg::CH_QUOTE)
                        && r_third_q;
    assign num = r_dv && !((r_count == CW'(1)) && tlnp_pkg::is_prefix(r_first));

    always_comb begin
        o_result.token_length = r_count[4:0];
        o_result.truncated    = r_ovf;
        if (is_literal) begin
            o_result.is_number    = 1'b1;
            o_result.number_value = signed'({24'd0, r_second});
        end else begin
            o_result.is_number    = num;
            o_result.number_value = num ? signed'(r_acc) : 32'sd0;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_acc     = r_acc;
        n_radix   = r_radix;
        n_dv      = r_dv;
        n_first   = r_first;
        n_second  = r_second;
        n_third_q = r_third_q;
        n_ovf     = r_ovf;
        o_emit    = 1'b0;
        unique case (r_mode)
            tlnp_pkg::MODE_SKIP: begin
                if (i_eoi || i_char == tlnp_pkg::CH_NEWLINE) begin
                    n_mode = tlnp_pkg::MODE_IDLE;
                end
            end
            tlnp_pkg::MODE_TOKEN: begin
                if (tok_char) begin
                    n_count   = a_count;
                    n_acc     = a_acc;
                    n_radix   = a_radix;
                    n_dv      = a_dv;
                    n_first   = a_first;
                    n_second  = a_second;
                    n_third_q = a_third_q;
                    n_ovf     = a_ovf;
                end else if (is_comment) begin
                    // a newline that ends the // already ends the comment
                    n_mode = (i_eoi || i_char == tlnp_pkg::CH_NEWLINE)
                             ? tlnp_pkg::MODE_IDLE : tlnp_pkg::MODE_SKIP;
                end else begin
                    o_emit = 1'b1;
                    n_mode = tlnp_pkg::MODE_IDLE;
                end
            end
            default: begin
                n_mode = tlnp_pkg::MODE_IDLE;
                if (tok_char) begin
                    n_mode    = tlnp_pkg::MODE_TOKEN;
                    n_count   = a_count;
                    n_acc     = a_acc;
                    n_radix   = a_radix;
                    n_dv      = a_dv;
                    n_first   = a_first;
                    n_second  = a_second;
                    n_third_q = a_third_q;
                    n_ovf     = a_ovf;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tlnp_pkg::MODE_IDLE;
            r_count   <= '0;
            r_acc     <= '0;
            r_radix   <= tlnp_pkg::RADIX_DEC;
            r_dv      <= 1'b1;
            r_first   <= '0;
            r_second  <= '0;
            r_third_q <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_acc     <= n_acc;
            r_radix   <= n_radix;
            r_dv      <= n_dv;
            r_first   <= n_first;
            r_second  <= n_second;
            r_third_q <= n_third_q;
            r_ovf     <= n_ovf;
        end
    end

endmodule

[sv/token_lexer_number_parser.sv]
// Token lexer with radix-prefixed number parsing. The block takes one source byte per
// cycle. A beat lands in the input register; when the core steps on it, the lexer state and
// the digit shift-add update from it, and a finished token's result is written to the
// output register at that same edge; o_valid comes from that register. One beat per cycle
// is sustained. The only stall is a token end that finds the output register still full
// and not being taken. o_ready is low while i_rst_n is low.
// Bytes 33..126 build a token, anything else (and i_end_of_input) ends it; a token of
// exactly // swallows input up to the next newline.
// Depends on tlnp_pkg and tlnp_core.
module token_lexer_number_parser #(
    parameter int MAX_TOKEN_LEN = tlnp_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_in_char,
    input  logic               i_end_of_input,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_number,
    output logic signed [31:0] o_number_value,
    output logic [4:0]         o_token_length,
    output logic               o_truncated
);

    logic              r_in_v;
    logic [7:0]        r_in_char;
    logic              r_in_eoi;
    logic              r_out_v;
    tlnp_pkg::t_result r_out;

    logic              step;
    logic              emit;
    tlnp_pkg::t_result result;

    tlnp_core #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_eoi    (r_in_eoi),
        .o_emit   (emit),
        .o_result (result)
    );

    // Advance unless a result would overwrite one still waiting
    assign step    = r_in_v && (!emit || !r_out_v || i_ready);
    assign o_ready = i_rst_n && (!r_in_v || step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_in_char;
            r_in_eoi  <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step && emit) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_v;
    assign o_is_number    = r_out.is_number;
    assign o_number_value = r_out.number_value;
    assign o_token_length = r_out.token_length;
    assign o_truncated    = r_out.truncated;

endmodule

[sv/tlnp_checker.sv]
// Port-level checks for token_lexer_number_parser, bound to the top level.
// Depends on tlnp_pkg and token_lexer_number_parser_assert.svh.
`include "token_lexer_number_parser_assert.svh"

module tlnp_checker #(
    parameter int MAX_TOKEN_LEN = tlnp_pkg::MAX_TOKEN_LEN_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [7:0]         i_in_char,
    input logic               i_end_of_input,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_is_number,
    input logic signed [31:0] o_number_value,
    input logic [4:0]         o_token_length,
    input logic               o_truncated
);

    logic        in_stall;
    logic [8:0]  in_beat;
    logic        out_stall;
    logic [38:0] out_beat;

    assign in_stall  = i_valid && !o_ready;
    assign in_beat   = {i_in_char, i_end_of_input};
    assign out_stall = o_valid && !i_ready;
    assign out_beat  = {o_is_number, o_number_value, o_token_length, o_truncated};

    // A stalled source beat holds its payload
    `TLNP_ASSERT_NEXT(a_in_hold, in_stall, i_valid && $stable(in_beat), "source beat changed")

    // A stalled result beat holds its payload
    `TLNP_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(out_beat), "result beat changed")

    // Input backpressure only comes from a full, blocked output
    `TLNP_ASSERT_NOW(a_stall_cause, !o_ready, out_stall, "input stalled without backpressure")

    `TLNP_ASSERT_NOW(a_zero_value, o_valid && !o_is_number, o_number_value == 32'sd0, "value set")

    // Truncated tokens report the saturated length
    `TLNP_ASSERT_NOW(a_trunc_len, o_valid && o_truncated, o_token_length == 5'(MAX_TOKEN_LEN), "len")

endmodule

bind token_lexer_number_parser tlnp_checker #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
) u_tlnp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_in_char      (i_in_char),
    .i_end_of_input (i_end_of_input),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_is_number    (o_is_number),
    .o_number_value (o_number_value),
    .o_token_length (o_token_length),
    .o_truncated    (o_truncated)
);
